### sv/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg
// Shared types and constants of the ordered segment alignment block.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int unsigned MAX_CLUSTERS_DEF = 64;
  localparam int unsigned MAX_DIMS_DEF     = 64;
  localparam int unsigned FRAME_BITS_DEF   = 16;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned COST_W  = 48;

  localparam logic [COST_W-1:0] COST_UNR  = '1;
  localparam logic [COST_W-1:0] COST_MAXR = 48'hFFFF_FFFF_FFFE;

  localparam logic [5:0] RED_LOW_DIMS  = 6'd14;
  localparam logic [5:0] RED_EXTRA_DIM = 6'd42;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [1:0] REG_REDUCED_DIMS = 2'd2;

  localparam logic [6:0] NUM_CLUSTERS_RST = 7'd64;
  localparam logic [6:0] NUM_DIMS_RST     = 7'd43;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ACC_RD,
    OP_ACC_MUL,
    OP_ACC_WR,
    OP_DP_RD,
    OP_DP_EX,
    OP_CP_RD,
    OP_CP_WR,
    OP_FIN,
    OP_OUT_RD,
    OP_OUT_LD,
    OP_CLR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic counts;
    logic is_end;
    logic last_frame;
    logic lower_unr;
    logic stay;
    logic out_free;
  } stat_t;

endpackage

### sv/osa_ctrl.sv
// ----------------------------------------------------------------------------
// osa_ctrl
// Sequencer: accumulation over centres, DP sweep, row copies and output.
// ----------------------------------------------------------------------------
module osa_ctrl import osa_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stat_t                           stat_i,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] k_last_i,
  output cmd_t                            cmd_o,
  output logic [$clog2(MAX_CLUSTERS)-1:0] c_idx_o,
  output logic [$clog2(MAX_CLUSTERS)-1:0] j_idx_o
);

  localparam int unsigned CW = $clog2(MAX_CLUSTERS);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DEC     = 13'b0000000000010,
    S_ACC_RD  = 13'b0000000000100,
    S_ACC_MUL = 13'b0000000001000,
    S_ACC_WR  = 13'b0000000010000,
    S_DP_RD   = 13'b0000000100000,
    S_DP_EX   = 13'b0000001000000,
    S_CP_RD   = 13'b0000010000000,
    S_CP_WR   = 13'b0000100000000,
    S_FIN     = 13'b0001000000000,
    S_OUT_RD  = 13'b0010000000000,
    S_OUT_LD  = 13'b0100000000000,
    S_CLR     = 13'b1000000000000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  c_q, c_d;
  logic [CW-1:0]  j_q, j_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign c_idx_o    = c_q;
  assign j_idx_o    = j_q;

  always_comb begin
    state_d   = state_q;
    c_d       = c_q;
    j_d       = j_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        c_d = '0;
        if (stat_i.is_load) begin
          state_d = S_IDLE;
        end else if (stat_i.counts) begin
          state_d = S_ACC_RD;
        end else if (stat_i.is_end) begin
          c_d     = k_last_i;
          state_d = S_DP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACC_RD: begin
        cmd_o.op = OP_ACC_RD;
        state_d  = S_ACC_MUL;
      end
      S_ACC_MUL: begin
        cmd_o.op = OP_ACC_MUL;
        state_d  = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.op = OP_ACC_WR;
        if (c_q == k_last_i) begin
          if (stat_i.is_end) begin
            c_d     = k_last_i;
            state_d = S_DP_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_ACC_RD;
        end
      end
      S_DP_RD: begin
        cmd_o.op = OP_DP_RD;
        state_d  = S_DP_EX;
      end
      S_DP_EX: begin
        cmd_o.op = OP_DP_EX;
        if (c_q == '0) begin
          state_d = S_FIN;
        end else if (stat_i.lower_unr || stat_i.stay) begin
          c_d     = c_q - 1'b1;
          state_d = S_DP_RD;
        end else begin
          // diagonal step: copy the end row of the path below
          j_d     = '0;
          state_d = S_CP_RD;
        end
      end
      S_CP_RD: begin
        cmd_o.op = OP_CP_RD;
        state_d  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.op = OP_CP_WR;
        if (j_q == c_q - 1'b1) begin
          c_d     = c_q - 1'b1;
          state_d = S_DP_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        c_d      = '0;
        state_d  = stat_i.last_frame ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        cmd_o.op = OP_OUT_RD;
        state_d  = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.op = OP_OUT_LD;
        if (stat_i.out_free) begin
          if (c_q == k_last_i) begin
            state_d = S_CLR;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      j_q     <= j_d;
    end
  end

endmodule

### sv/osa_dp.sv
// ----------------------------------------------------------------------------
// osa_dp
// Datapath: configuration registers, centre, distance, cost and end-index
// memories, squared-difference unit, saturating adder and output register.
// ----------------------------------------------------------------------------
module osa_dp import osa_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_DIMS     = MAX_DIMS_DEF,
  parameter int unsigned FRAME_BITS   = FRAME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [PADDR_W-1:0]              paddr,
  input  logic [PDATA_W-1:0]              pwdata,
  output logic [PDATA_W-1:0]              prdata,
  input  logic                            req_type_i,
  input  logic [5:0]                      centre_index_i,
  input  logic [5:0]                      dim_index_i,
  input  logic signed [15:0]              value_i,
  input  logic                            forced_boundary_i,
  input  logic                            last_frame_i,
  input  cmd_t                            cmd_i,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] c_idx_i,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] j_idx_i,
  output stat_t                           stat_o,
  output logic [$clog2(MAX_CLUSTERS)-1:0] k_last_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [5:0]                      segment_index_o,
  output logic [15:0]                     segment_end_o,
  output logic [47:0]                     total_cost_o,
  output logic                            last_o
);

  localparam int unsigned CW      = $clog2(MAX_CLUSTERS);
  localparam int unsigned DW      = $clog2(MAX_DIMS);
  localparam int unsigned DIM_LIM = (MAX_DIMS < 64) ? MAX_DIMS : 64;
  localparam logic [FRAME_BITS-1:0] END_NONE = '1;
  localparam logic [FRAME_BITS-1:0] END_MAXR = END_NONE - 1'b1;

  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COST_MAXR}) ? COST_MAXR : s[COST_W-1:0];
  endfunction

  // configuration
  logic [6:0] num_clusters_q, num_dims_q;
  logic       reduced_dims_q;
  logic [6:0] k_eff, nd_eff;
  logic [5:0] nd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= NUM_CLUSTERS_RST;
      num_dims_q     <= NUM_DIMS_RST;
      reduced_dims_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NUM_CLUSTERS: num_clusters_q <= pwdata[6:0];
        REG_NUM_DIMS:     num_dims_q     <= pwdata[6:0];
        REG_REDUCED_DIMS: reduced_dims_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_CLUSTERS: prdata = {25'b0, num_clusters_q};
      REG_NUM_DIMS:     prdata = {25'b0, num_dims_q};
      REG_REDUCED_DIMS: prdata = {31'b0, reduced_dims_q};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (num_clusters_q == 7'd0) k_eff = 7'd1;
    else if (32'(num_clusters_q) > MAX_CLUSTERS) k_eff = 7'(MAX_CLUSTERS);
    else k_eff = num_clusters_q;
    if (num_dims_q == 7'd0) nd_eff = 7'd1;
    else if (32'(num_dims_q) > DIM_LIM) nd_eff = 7'(DIM_LIM);
    else nd_eff = num_dims_q;
  end

  assign k_last_o = CW'(k_eff - 7'd1);
  assign nd_last  = 6'(nd_eff - 7'd1);

  // latched transaction
  logic               req_q, forced_q, lastf_q;
  logic [5:0]         d_q;
  logic signed [15:0] v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      req_q    <= req_type_i;
      d_q      <= dim_index_i;
      v_q      <= value_i;
      forced_q <= forced_boundary_i;
      lastf_q  <= last_frame_i;
    end
  end

  // centre store
  logic [15:0]       cmem [2**(CW+DW)];
  logic [15:0]       cen_rd_q;
  logic              cen_we;

  assign cen_we = (cmd_i.op == OP_LATCH) && !req_type_i
                  && (32'(centre_index_i) < MAX_CLUSTERS) && (32'(dim_index_i) < MAX_DIMS);

  always_ff @(posedge clk_i) begin
    if (cen_we) cmem[{CW'(centre_index_i), DW'(dim_index_i)}] <= value_i;
    if (cmd_i.op == OP_ACC_RD) cen_rd_q <= cmem[{c_idx_i, DW'(d_q)}];
  end

  // squared difference
  logic [16:0] diff, diff_neg;
  logic [15:0] mag;
  logic [31:0] prod_q;

  assign diff     = {v_q[15], v_q} - {cen_rd_q[15], cen_rd_q};
  assign diff_neg = ~diff + 17'd1;
  assign mag      = diff[16] ? diff_neg[15:0] : diff[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACC_MUL) prod_q <= mag * mag;
  end

  // partial distances
  logic [COST_W-1:0]       pdmem [MAX_CLUSTERS];
  logic [COST_W-1:0]       pd_rd_q, pd_val, pd_sum;
  logic                    pd_rv_q;
  logic [MAX_CLUSTERS-1:0] pd_vld_q;

  assign pd_val = pd_rv_q ? pd_rd_q : '0;
  assign pd_sum = sat_add(pd_val, COST_W'(prod_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACC_WR) pdmem[c_idx_i] <= pd_sum;
    if (cmd_i.op == OP_ACC_RD || cmd_i.op == OP_DP_RD) begin
      pd_rd_q <= pdmem[c_idx_i];
      pd_rv_q <= pd_vld_q[c_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_vld_q <= '0;
    end else if (cmd_i.op == OP_FIN || cmd_i.op == OP_CLR) begin
      pd_vld_q <= '0;
    end else if (cmd_i.op == OP_ACC_WR) begin
      pd_vld_q[c_idx_i] <= 1'b1;
    end
  end

  // path costs
  logic [COST_W-1:0]       pcmem [MAX_CLUSTERS];
  logic [COST_W-1:0]       pca_q, pcb_q, pca, pcb, pc_sel, pc_new;
  logic                    pca_v_q, pcb_v_q;
  logic [MAX_CLUSTERS-1:0] pc_vld_q;
  logic [CW-1:0]           pca_addr, c_below;
  logic                    dp_we;
  logic [FRAME_BITS-1:0]   fc_q, endv;

  assign c_below  = c_idx_i - 1'b1;
  assign pca_addr = (cmd_i.op == OP_OUT_RD) ? k_last_o : c_idx_i;
  assign pca      = pca_v_q ? pca_q : COST_UNR;
  assign pcb      = pcb_v_q ? pcb_q : COST_UNR;
  assign endv     = (fc_q == END_MAXR) ? END_MAXR : fc_q + 1'b1;

  assign stat_o.is_load    = !req_q;
  assign stat_o.counts     = req_q && (d_q <= nd_last)
                             && (!reduced_dims_q || d_q < RED_LOW_DIMS || d_q == RED_EXTRA_DIM);
  assign stat_o.is_end     = req_q && (d_q == nd_last);
  assign stat_o.last_frame = lastf_q;
  assign stat_o.lower_unr  = (pcb == COST_UNR);
  assign stat_o.stay       = (pca < pcb) && !forced_q;

  always_comb begin
    if (c_idx_i == '0) pc_sel = (fc_q == '0) ? '0 : pca;
    else if (stat_o.stay) pc_sel = pca;
    else pc_sel = pcb;
  end

  assign pc_new = sat_add(pc_sel, pd_val);
  assign dp_we  = (cmd_i.op == OP_DP_EX) && ((c_idx_i == '0) || !stat_o.lower_unr);

  always_ff @(posedge clk_i) begin
    if (dp_we) pcmem[c_idx_i] <= pc_new;
    if (cmd_i.op == OP_DP_RD || cmd_i.op == OP_OUT_RD) begin
      pca_q   <= pcmem[pca_addr];
      pca_v_q <= pc_vld_q[pca_addr];
      pcb_q   <= pcmem[c_below];
      pcb_v_q <= pc_vld_q[c_below];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_vld_q <= '0;
      fc_q     <= '0;
    end else if (cmd_i.op == OP_CLR) begin
      pc_vld_q <= '0;
      fc_q     <= '0;
    end else begin
      if (dp_we) pc_vld_q[c_idx_i] <= 1'b1;
      if (cmd_i.op == OP_FIN && fc_q != END_MAXR) fc_q <= fc_q + 1'b1;
    end
  end

  // path end rows; on each diagonal step a row's lower entries are copied from the row below
  logic [FRAME_BITS-1:0]   pemem [2**(2*CW)];
  logic [FRAME_BITS-1:0]   pe_rd_q, pe_wd;
  logic                    pe_rv_q, pe_we;
  logic [2*CW-1:0]         pe_wa, pe_ra;
  logic [MAX_CLUSTERS-1:0] row_vld_q;

  assign pe_we = dp_we || (cmd_i.op == OP_CP_WR);
  assign pe_wa = (cmd_i.op == OP_CP_WR) ? {c_idx_i, j_idx_i} : {c_idx_i, c_idx_i};
  assign pe_wd = (cmd_i.op == OP_CP_WR) ? pe_rd_q : endv;
  assign pe_ra = (cmd_i.op == OP_OUT_RD) ? {k_last_o, c_idx_i} : {c_below, j_idx_i};

  always_ff @(posedge clk_i) begin
    if (pe_we) pemem[pe_wa] <= pe_wd;
    if (cmd_i.op == OP_CP_RD || cmd_i.op == OP_OUT_RD) begin
      pe_rd_q <= pemem[pe_ra];
      pe_rv_q <= row_vld_q[k_last_o];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.op == OP_CLR) begin
      row_vld_q <= '0;
    end else if (dp_we) begin
      row_vld_q[c_idx_i] <= 1'b1;
    end
  end

  // output register
  logic out_vld_q, out_load;

  assign stat_o.out_free = !out_vld_q || !out_stall_i;
  assign out_load        = (cmd_i.op == OP_OUT_LD) && stat_o.out_free;
  assign out_valid_o     = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      segment_index_o <= 6'(c_idx_i);
      segment_end_o   <= pe_rv_q ? 16'(pe_rd_q) : 16'(END_NONE);
      total_cost_o    <= pca;
      last_o          <= (c_idx_i == k_last_o);
    end
  end

endmodule

### sv/ordered_segment_alignment_top.sv
// ----------------------------------------------------------------------------
// ordered_segment_alignment_top
// Left-to-right segmental alignment of feature frames onto K ordered centres.
// ----------------------------------------------------------------------------
// Centre load: stored when latched. Counted frame element: centres are taken one
// at a time through the shared squared-difference unit (read, multiply, write).
// Frame end adds the DP sweep, plus a copy of c entries per diagonal step at c.
// Last frame adds one result per centre, each loaded while the output is free.
// Reset: asynchronous, clears control state and valid bits; no clearing pass.
module ordered_segment_alignment_top import osa_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_DIMS     = MAX_DIMS_DEF,
  parameter int unsigned FRAME_BITS   = FRAME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [5:0]         centre_index_i,
  input  logic [5:0]         dim_index_i,
  input  logic signed [15:0] value_i,
  input  logic               forced_boundary_i,
  input  logic               last_frame_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         segment_index_o,
  output logic [15:0]        segment_end_o,
  output logic [47:0]        total_cost_o,
  output logic               last_o
);

  localparam int unsigned CW = $clog2(MAX_CLUSTERS);

  cmd_t          cmd;
  stat_t         stat;
  logic [CW-1:0] c_idx, j_idx, k_last;

  assign pready = 1'b1;

  osa_ctrl #(
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .k_last_i   (k_last),
    .cmd_o      (cmd),
    .c_idx_o    (c_idx),
    .j_idx_o    (j_idx)
  );

  osa_dp #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .MAX_DIMS    (MAX_DIMS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .req_type_i        (req_type_i),
    .centre_index_i    (centre_index_i),
    .dim_index_i       (dim_index_i),
    .value_i           (value_i),
    .forced_boundary_i (forced_boundary_i),
    .last_frame_i      (last_frame_i),
    .cmd_i             (cmd),
    .c_idx_i           (c_idx),
    .j_idx_i           (j_idx),
    .stat_o            (stat),
    .k_last_o          (k_last),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .segment_index_o   (segment_index_o),
    .segment_end_o     (segment_end_o),
    .total_cost_o      (total_cost_o),
    .last_o            (last_o)
  );

endmodule

### sv/osa_chk.sv
// ----------------------------------------------------------------------------
// osa_chk
// Port-level checks of the alignment block, bound to the top level.
// ----------------------------------------------------------------------------
module osa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  segment_index_o,
  input logic [15:0] segment_end_o,
  input logic [47:0] total_cost_o,
  input logic        last_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(segment_index_o) && $stable(segment_end_o)
                                   && $stable(total_cost_o) && $stable(last_o))
    else $error("stalled result changed");

  // no new transaction while a run still has results to hand out
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a result run");

  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without the block being busy");

endmodule

bind ordered_segment_alignment_top osa_chk u_osa_chk (.*);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for ordered_segment_alignment_top. It loads centre
// vectors, streams frames through a sequence of register settings and checks
// every segment result against a predictor of the alignment.
// ----------------------------------------------------------------------------
module tb_top import osa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  seg;
    logic [15:0] seg_end;
    logic [47:0] cost;
    logic        last;
  } seg_result_t;

  localparam int unsigned NC = MAX_CLUSTERS_DEF;
  localparam int unsigned ND = MAX_DIMS_DEF;
  localparam logic [15:0] END_NONE = 16'hFFFF;
  localparam logic [15:0] END_MAXR = 16'hFFFE;

  class align_scoreboard;
    logic [15:0] centre_mem [NC*ND];
    bit          written [NC*ND];
    logic [47:0] part_dist [NC];
    logic [47:0] cost [NC];
    logic [15:0] ends [NC*NC];
    logic [15:0] frames;
    logic [6:0]  k_reg;
    logic [6:0]  nd_reg;
    logic        red;
    seg_result_t pending [$];
    int          errors;

    function new();
      k_reg = NUM_CLUSTERS_RST;
      nd_reg = NUM_DIMS_RST;
      red = 1'b0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
      clear_run();
    endfunction

    function int eff_k();
      if (k_reg == 0) return 1;
      if (k_reg > NC) return NC;
      return k_reg;
    endfunction

    function int eff_nd();
      if (nd_reg == 0) return 1;
      if (nd_reg > ND) return ND;
      return nd_reg;
    endfunction

    function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COST_MAXR}) ? COST_MAXR : s[47:0];
    endfunction

    function void clear_run();
      foreach (part_dist[i]) begin
        part_dist[i] = '0;
        cost[i] = COST_UNR;
      end
      foreach (ends[i]) ends[i] = END_NONE;
      frames = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_NUM_CLUSTERS: k_reg = val[6:0];
        REG_NUM_DIMS: nd_reg = val[6:0];
        REG_REDUCED_DIMS: red = val[0];
        default: ;
      endcase
    endfunction

    function void advance_paths(int k, bit forced);
      int endv;
      endv = frames + 1;
      if (endv > END_MAXR) endv = END_MAXR;
      if (frames == 0) begin
        cost[0] = sat_add('0, part_dist[0]);
        for (int c = 1; c < NC; c++) cost[c] = COST_UNR;
        ends[0] = 16'(endv);
        return;
      end
      for (int c = k - 1; c >= 1; c--) begin
        if (cost[c-1] == COST_UNR) continue;
        if (cost[c] < cost[c-1] && !forced) begin
          cost[c] = sat_add(cost[c], part_dist[c]);
        end else begin
          cost[c] = sat_add(cost[c-1], part_dist[c]);
          for (int j = 0; j < c; j++) ends[c*NC+j] = ends[(c-1)*NC+j];
        end
        ends[c*NC+c] = 16'(endv);
      end
      cost[0] = sat_add(cost[0], part_dist[0]);
      ends[0] = 16'(endv);
    endfunction

    function void note_input(logic rt, logic [5:0] ci, logic [5:0] d,
                             logic [15:0] v, logic fb, logic lf);
      int k, nd, diff;
      longint unsigned sq;
      seg_result_t r;
      k = eff_k();
      nd = eff_nd();
      if (!rt) begin
        centre_mem[ci*ND+d] = v;
        written[ci*ND+d] = 1'b1;
        return;
      end
      if (d < nd && (!red || d < RED_LOW_DIMS || d == RED_EXTRA_DIM)) begin
        for (int c = 0; c < k; c++) begin
          diff = int'($signed(v)) - int'($signed(centre_mem[c*ND+d]));
          if (diff < 0) diff = -diff;
          sq = longint'(diff) * longint'(diff);
          part_dist[c] = sat_add(part_dist[c], sq[47:0]);
        end
      end
      if (d != nd - 1) return;
      advance_paths(k, fb);
      foreach (part_dist[i]) part_dist[i] = '0;
      if (frames < END_MAXR) frames++;
      if (lf) begin
        for (int c = 0; c < k; c++) begin
          r.seg = 6'(c);
          r.seg_end = ends[(k-1)*NC+c];
          r.cost = cost[k-1];
          r.last = (c == k - 1);
          pending = {pending, r};
        end
        clear_run();
      end
    endfunction

    function void check_result(seg_result_t act);
      seg_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result: segment_index %0d", act.seg);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.seg !== exp.seg) begin
        $error("segment_index: expected %0d, actual %0d", exp.seg, act.seg);
        errors++;
      end
      if (act.seg_end !== exp.seg_end) begin
        $error("segment_end: expected %0d, actual %0d", exp.seg_end, act.seg_end);
        errors++;
      end
      if (act.cost !== exp.cost) begin
        $error("total_cost: expected %0h, actual %0h", exp.cost, act.cost);
        errors++;
      end
      if (act.last !== exp.last) begin
        $error("last: expected %0b, actual %0b", exp.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [5:0]         centre_index_i = '0;
  logic [5:0]         dim_index_i = '0;
  logic signed [15:0] value_i = '0;
  logic               forced_boundary_i = 1'b0;
  logic               last_frame_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         segment_index_o;
  logic [15:0]        segment_end_o;
  logic [47:0]        total_cost_o;
  logic               last_o;

  align_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;
  int cur_k = 1;
  int cur_nd = 1;

  ordered_segment_alignment_top DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_input(req_type_i, centre_index_i, dim_index_i, value_i,
                    forced_boundary_i, last_frame_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({segment_index_o, segment_end_o, total_cost_o, last_o});
  end

  // Receiver stall pattern: switch between free-flowing, random and long stalls.
  int stall_mode = 0;
  int stall_run = 0;
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_item(bit rt, bit [5:0] ci, bit [5:0] d, logic [15:0] v,
                           bit fb, bit lf);
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    centre_index_i <= ci;
    dim_index_i <= d;
    value_i <= v;
    forced_boundary_i <= fb;
    last_frame_i <= lf;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  endtask

  // Drop valid, hold until every expected result is out, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Apply a setting and load any centre element it will read.
  task automatic configure(int k, int nd, bit red);
    reg_write(REG_NUM_CLUSTERS, k);
    reg_write(REG_NUM_DIMS, nd);
    reg_write(REG_REDUCED_DIMS, {31'b0, red});
    cur_k = sb.eff_k();
    cur_nd = sb.eff_nd();
    for (int c = 0; c < cur_k; c++)
      for (int d = 0; d < cur_nd; d++)
        if (!sb.written[c*ND+d])
          send_item(1'b0, 6'(c), 6'(d), pick_value(), 1'($urandom), 1'($urandom));
  endtask

  // Frames with shuffled elements, the frame-ending one last, some noise mixed in.
  task automatic run_frames(int n);
    int dims [$];
    int j, t;
    for (int f = 0; f < n; f++) begin
      dims.delete();
      for (int d = 0; d < cur_nd - 1; d++) dims = {dims, d};
      foreach (dims[i]) begin
        j = $urandom_range(0, dims.size() - 1);
        t = dims[i];
        dims[i] = dims[j];
        dims[j] = t;
      end
      if (cur_nd < 64 && $urandom_range(0, 2) == 0)
        dims.insert($urandom_range(0, dims.size()), $urandom_range(cur_nd, 63));
      foreach (dims[i]) begin
        if ($urandom_range(0, 9) == 0)
          send_item(1'b0, 6'($urandom), 6'($urandom), pick_value(), 1'($urandom),
                    1'($urandom));
        send_item(1'b1, 6'($urandom), 6'(dims[i]), pick_value(), 1'($urandom),
                  1'($urandom));
      end
      send_item(1'b1, 6'($urandom), 6'(cur_nd - 1), pick_value(),
                $urandom_range(0, 3) == 0, f == n - 1);
    end
  endtask

  initial begin
    #50ms;
    $display("ordered_segment_alignment_top regression: fail");
    $finish;
  end

  initial begin
    int cfg_k [4] = '{64, 0, 127, 2};
    int cfg_nd [4] = '{1, 0, 1, 127};
    bit cfg_red [4] = '{0, 0, 1, 1};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: two centres, three dims, extreme values.
    configure(2, 3, 0);
    send_item(1'b0, 0, 0, 16'h7FFF, 0, 0);
    send_item(1'b0, 0, 1, 16'h8000, 0, 0);
    send_item(1'b0, 0, 2, 16'h0000, 0, 0);
    send_item(1'b0, 1, 0, 16'h8000, 0, 0);
    send_item(1'b0, 1, 1, 16'h7FFF, 0, 0);
    send_item(1'b0, 1, 2, 16'hFFFF, 0, 0);
    send_item(1'b1, 0, 1, 16'h8000, 1, 1);
    send_item(1'b1, 0, 5, 16'h7FFF, 0, 0);
    send_item(1'b1, 0, 0, 16'h7FFF, 0, 0);
    send_item(1'b1, 0, 2, 16'h0001, 0, 0);
    send_item(1'b1, 0, 0, 16'h8000, 0, 0);
    send_item(1'b1, 0, 1, 16'h7FFF, 0, 0);
    send_item(1'b1, 0, 2, 16'h8000, 1, 0);
    send_item(1'b1, 0, 2, 16'h7FFF, 0, 0);
    send_item(1'b1, 0, 0, 16'h0000, 0, 0);
    send_item(1'b1, 0, 1, 16'h0000, 0, 0);
    send_item(1'b1, 0, 2, 16'h0000, 0, 1);
    drain();

    // Extreme settings, including values that act as 1 or as the maximum.
    foreach (cfg_k[i]) begin
      configure(cfg_k[i], cfg_nd[i], cfg_red[i]);
      run_frames(1);
      drain();
    end

    while (items_sent < 370) begin
      configure($urandom_range(1, 10), $urandom_range(1, 8), 1'($urandom));
      repeat ($urandom_range(1, 2)) run_frames($urandom_range(1, 3));
      drain();
    end

    drain();
    if (sb.pending.size() != 0) begin
      $error("results still expected at end: %0d", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("ordered_segment_alignment_top regression: pass");
    else
      $display("ordered_segment_alignment_top regression: fail");
    $finish;
  end
endmodule
